>>> rtl/sha1_byte_stream_hasher_macros.svh
// Assertion macros shared by the SHA-1 hasher RTL.
`ifndef SHA1_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA1_BYTE_STREAM_HASHER_MACROS_SVH

// Same-cycle implication, checked on aclk and disabled while aresetn is low.
`define SBH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk and disabled while aresetn is low.
`define SBH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sha1bs_pkg.sv
// Types, constants and round functions shared by the SHA-1 hasher modules.
`default_nettype none

package sha1bs_pkg;

    // Item kinds carried on the input tuser bit.
    localparam logic KIND_ABSORB = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    // Block fill and counter limits.
    localparam logic [5:0] FILL_FULL  = 6'd63;   // last byte slot of a block
    localparam logic [5:0] FILL_PRELEN = 6'd55;  // last byte before the length field
    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [2:0] WORD_LAST  = 3'd4;
    localparam logic [7:0] PAD_BYTE   = 8'h80;

    // Initial chaining values.
    localparam logic [31:0] H_INIT [5] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PADZ,
        ST_LEN,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } state_t;

    // Datapath operations.
    typedef enum logic [3:0] {
        DP_NOP,
        DP_ABSORB,
        DP_PAD80,
        DP_ZERO,
        DP_LEN,
        DP_LOAD,
        DP_ROUND,
        DP_ADD,
        DP_NEXT,
        DP_INIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic [5:0] fill;
        logic       round_last;
        logic       word_last;
    } dp_stat_t;

    // Round constant for a given round.
    function automatic logic [31:0] round_k(input logic [6:0] r);
        logic [31:0] k;
        case (r) inside
            [7'd0:7'd19]:  k = 32'h5a827999;
            [7'd20:7'd39]: k = 32'h6ed9eba1;
            [7'd40:7'd59]: k = 32'h8f1bbcdc;
            default:       k = 32'hca62c1d6;
        endcase
        return k;
    endfunction

    // Boolean round function for a given round.
    function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        case (r) inside
            [7'd0:7'd19]:  f = d ^ (b & (c ^ d));
            [7'd40:7'd59]: f = (b & c) | (d & (b | c));
            default:       f = b ^ c ^ d;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

>>> rtl/sha1bs_datapath.sv
// Datapath: byte gather and schedule window, round registers and chaining words.
`default_nettype none
`include "sha1_byte_stream_hasher_macros.svh"

module sha1bs_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  sha1bs_pkg::dp_cmd_t cmd,
    output sha1bs_pkg::dp_stat_t stat,
    input  logic [7:0]          in_byte,
    output logic [31:0]         digest_word,
    output logic [2:0]          word_index
);
    import sha1bs_pkg::*;

    // Block buffer; word i sits at bits 511-32i down. It also serves as the
    // 16-word message schedule window during compression.
    logic [511:0] blk_reg, blk_next;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  a_next, b_next, c_next, d_next, e_next;
    logic [31:0]  h_reg [5];
    logic [31:0]  h_next [5];
    logic [31:0]  work_vec [5];
    logic [6:0]   round_reg, round_next;
    logic [5:0]   fill_reg, fill_next;
    logic [60:0]  bcnt_reg, bcnt_next;   // message length in bytes
    logic [2:0]   idx_reg, idx_next;

    logic [63:0]  len_bits;
    logic [7:0]   len_byte;
    logic [31:0]  w0, w2, w8, w13, w_new, t_sum;

    // Length field byte for the current slot, most significant first.
    assign len_bits = {bcnt_reg, 3'b000};
    assign len_byte = len_bits[{~fill_reg[2:0], 3'b000} +: 8];

    // Schedule taps and the expanded word.
    assign w0    = blk_reg[511:480];
    assign w2    = blk_reg[447:416];
    assign w8    = blk_reg[255:224];
    assign w13   = blk_reg[95:64];
    assign w_new = {w13[30:0] ^ w8[30:0] ^ w2[30:0] ^ w0[30:0],
                    w13[31] ^ w8[31] ^ w2[31] ^ w0[31]};

    // One SHA-1 round.
    assign t_sum = {a_reg[26:0], a_reg[31:27]} + round_f(round_reg, b_reg, c_reg, d_reg)
                 + e_reg + w0 + round_k(round_reg);

    assign work_vec[0] = a_reg;
    assign work_vec[1] = b_reg;
    assign work_vec[2] = c_reg;
    assign work_vec[3] = d_reg;
    assign work_vec[4] = e_reg;

    // Next-value logic for all datapath registers.
    always_comb begin
        blk_next   = blk_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        e_next     = e_reg;
        round_next = round_reg;
        fill_next  = fill_reg;
        bcnt_next  = bcnt_reg;
        idx_next   = idx_reg;
        for (int i = 0; i < 5; i++) begin
            h_next[i] = h_reg[i];
        end
        case (cmd.op)
            DP_ABSORB: begin
                blk_next  = {blk_reg[503:0], in_byte};
                fill_next = fill_reg + 6'd1;
                bcnt_next = bcnt_reg + 61'd1;
            end
            DP_PAD80: begin
                blk_next  = {blk_reg[503:0], PAD_BYTE};
                fill_next = fill_reg + 6'd1;
            end
            DP_ZERO: begin
                blk_next  = {blk_reg[503:0], 8'h00};
                fill_next = fill_reg + 6'd1;
            end
            DP_LEN: begin
                blk_next  = {blk_reg[503:0], len_byte};
                fill_next = fill_reg + 6'd1;
            end
            DP_LOAD: begin
                a_next     = h_reg[0];
                b_next     = h_reg[1];
                c_next     = h_reg[2];
                d_next     = h_reg[3];
                e_next     = h_reg[4];
                round_next = '0;
            end
            DP_ROUND: begin
                a_next     = t_sum;
                b_next     = a_reg;
                c_next     = {b_reg[1:0], b_reg[31:2]};
                d_next     = c_reg;
                e_next     = d_reg;
                blk_next   = {blk_reg[479:0], w_new};
                round_next = round_reg + 7'd1;
            end
            DP_ADD: begin
                for (int i = 0; i < 5; i++) begin
                    h_next[i] = h_reg[i] + work_vec[i];
                end
            end
            DP_NEXT: begin
                idx_next = idx_reg + 3'd1;
            end
            DP_INIT: begin
                for (int i = 0; i < 5; i++) begin
                    h_next[i] = H_INIT[i];
                end
                fill_next = '0;
                bcnt_next = '0;
                idx_next  = '0;
            end
            default: begin
            end
        endcase
    end

    // Control and chaining state; reset clears the counters and restores the initial chaining values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            round_reg <= '0;
            fill_reg  <= '0;
            bcnt_reg  <= '0;
            idx_reg   <= '0;
            for (int i = 0; i < 5; i++) begin
                h_reg[i] <= H_INIT[i];
            end
        end else begin
            round_reg <= round_next;
            fill_reg  <= fill_next;
            bcnt_reg  <= bcnt_next;
            idx_reg   <= idx_next;
            for (int i = 0; i < 5; i++) begin
                h_reg[i] <= h_next[i];
            end
        end
    end

    // Payload registers without reset.
    always_ff @(posedge aclk) begin
        blk_reg <= blk_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
    end

    assign stat.fill       = fill_reg;
    assign stat.round_last = (round_reg == ROUND_LAST);
    assign stat.word_last  = (idx_reg == WORD_LAST);
    assign digest_word     = h_reg[idx_reg];
    assign word_index      = idx_reg;

    `SBH_ASSERT_NOW(a_add_on_boundary, cmd.op == DP_ADD, fill_reg == 6'd0,
        "chaining update with a partly filled block")
    `SBH_ASSERT_NOW(a_len_slot, cmd.op == DP_LEN, fill_reg[5:3] == 3'b111,
        "length byte written outside the length field")
    `SBH_ASSERT_NOW(a_round_range, cmd.op == DP_ROUND, round_reg <= ROUND_LAST,
        "round counter ran past the last round")

endmodule

`default_nettype wire

>>> rtl/sha1bs_ctrl.sv
// Controller: sequences absorb, padding, compression and digest output.
`default_nettype none
`include "sha1_byte_stream_hasher_macros.svh"

module sha1bs_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output sha1bs_pkg::dp_cmd_t  cmd,
    input  sha1bs_pkg::dp_stat_t stat
);
    import sha1bs_pkg::*;

    state_t state_reg, state_next;
    logic   fin_reg, fin_next;   // a finish word is being processed
    logic   len_reg, len_next;   // length field is in the current block

    // State and flag registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fin_reg   <= 1'b0;
            len_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
            len_reg   <= len_next;
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (stat.fill == FILL_FULL) begin
                        state_next = ST_LOAD;
                    end else if (s_tuser == KIND_FINISH && stat.fill == FILL_PRELEN) begin
                        state_next = ST_LEN;
                    end else if (s_tuser == KIND_FINISH) begin
                        state_next = ST_PADZ;
                    end
                end
            end
            ST_PADZ: begin
                if (stat.fill == FILL_FULL) begin
                    state_next = ST_LOAD;
                end else if (stat.fill == FILL_PRELEN) begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN: begin
                if (stat.fill == FILL_FULL) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                if (stat.round_last) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                if (!fin_reg) begin
                    state_next = ST_IDLE;
                end else if (!len_reg) begin
                    state_next = ST_PADZ;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (m_tready && stat.word_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output and flag logic.
    always_comb begin
        cmd.op   = DP_NOP;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        fin_next = fin_reg;
        len_next = len_reg;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser == KIND_FINISH) begin
                        cmd.op   = DP_PAD80;
                        fin_next = 1'b1;
                    end else begin
                        cmd.op = DP_ABSORB;
                    end
                end
            end
            ST_PADZ: begin
                cmd.op = DP_ZERO;
            end
            ST_LEN: begin
                cmd.op = DP_LEN;
                if (stat.fill == FILL_FULL) begin
                    len_next = 1'b1;
                end
            end
            ST_LOAD: begin
                cmd.op = DP_LOAD;
            end
            ST_ROUND: begin
                cmd.op = DP_ROUND;
            end
            ST_ADD: begin
                cmd.op = DP_ADD;
            end
            ST_EMIT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (stat.word_last) begin
                        cmd.op   = DP_INIT;
                        fin_next = 1'b0;
                        len_next = 1'b0;
                    end else begin
                        cmd.op = DP_NEXT;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    `SBH_ASSERT_NOW(a_one_side, 1'b1, !(s_tready && m_tvalid),
        "input accepted while digest output is active")
    `SBH_ASSERT_NEXT(a_round_end, state_reg == ST_ROUND && stat.round_last,
        state_reg == ST_ADD, "compression did not end after the last round")
    `SBH_ASSERT_NEXT(a_emit_done, state_reg == ST_EMIT && m_tready && stat.word_last,
        state_reg == ST_IDLE && !fin_reg && !len_reg,
        "hasher did not return to idle after the last digest word")
    `SBH_ASSERT_NOW(a_len_needs_fin, len_reg, fin_reg,
        "length field set outside a finish sequence")

endmodule

`default_nettype wire

>>> rtl/sha1_byte_stream_hasher.sv
// Top level of the SHA-1 byte stream hasher.
//
//   Channel  Dir  Ports                         Contents
//   s_       in   s_tvalid s_tready s_tdata     data_byte in tdata, kind in tuser
//                 s_tuser
//   m_       out  m_tvalid m_tready m_tdata     digest_word, word_index; last_word
//                 m_tlast                       in tlast
//
// An absorb word shifts one byte into the block; the 64th byte of a block starts
// a compression (load, 80 rounds at one round per cycle, chaining add). A finish
// word pads one byte per cycle up to the length field, shifts in eight length
// bytes, compresses once more (twice when more than 55 bytes were pending), then
// shows five digest words.
// Reset is synchronous on aresetn low and restores the initial chaining values.
// s_tready is low from a full block or a finish word until the work is done; the
// digest output stalls on m_tready without losing state.
`default_nettype none

module sha1_byte_stream_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] kind: 0 absorb, 1 finish
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
    output logic        m_tlast    // last_word
);
    import sha1bs_pkg::*;

    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic [31:0] digest_word;
    logic [2:0]  word_index;

    sha1bs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    sha1bs_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .in_byte     (s_tdata),
        .digest_word (digest_word),
        .word_index  (word_index)
    );

    // Result word packing.
    assign m_tdata = {5'b00000, word_index, digest_word};
    assign m_tlast = stat.word_last;

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for the SHA-1 byte stream hasher: random messages, bursty traffic.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sha1bs_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 400;
    localparam int RANDOM_ITEMS = 160;
    localparam int RANDOM_MESSAGES = 7;

    // Digest predictor and the queue of digest words it still expects.
    class sha1_scoreboard;
        typedef struct {
            logic [31:0] word;
            logic [2:0]  idx;
            logic        last;
        } digest_word_t;

        logic [31:0]  chain [5];
        logic [7:0]   blk [64];
        int unsigned  fill;
        logic [63:0]  bit_count;
        digest_word_t digest_q [$];
        int unsigned  errors;
        int unsigned  words_checked;
        int unsigned  messages;
        int unsigned  bytes_absorbed;
        int unsigned  extra_blocks;

        function new();
            errors = 0;
            words_checked = 0;
            messages = 0;
            bytes_absorbed = 0;
            extra_blocks = 0;
            restart();
        endfunction

        // Back to the initial chaining values with an empty block.
        function void restart();
            chain[0] = 32'h67452301;
            chain[1] = 32'hefcdab89;
            chain[2] = 32'h98badcfe;
            chain[3] = 32'h10325476;
            chain[4] = 32'hc3d2e1f0;
            foreach (blk[i]) blk[i] = 8'h00;
            fill = 0;
            bit_count = 64'd0;
        endfunction

        function logic [31:0] rot_left(input logic [31:0] v, input int n);
            return (v << n) | (v >> (32 - n));
        endfunction

        // One 80-round compression of the current block into the chain.
        function void compress();
            logic [31:0] w [80];
            logic [31:0] a, b, c, d, e, f, k, t;
            for (int r = 0; r < 16; r++)
                w[r] = {blk[4 * r], blk[4 * r + 1], blk[4 * r + 2], blk[4 * r + 3]};
            for (int r = 16; r < 80; r++)
                w[r] = rot_left(w[r - 3] ^ w[r - 8] ^ w[r - 14] ^ w[r - 16], 1);
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            e = chain[4];
            for (int r = 0; r < 80; r++) begin
                if (r < 20) begin
                    f = d ^ (b & (c ^ d));
                    k = 32'h5a827999;
                end else if (r < 40) begin
                    f = b ^ c ^ d;
                    k = 32'h6ed9eba1;
                end else if (r < 60) begin
                    f = (b & c) | (d & (b | c));
                    k = 32'h8f1bbcdc;
                end else begin
                    f = b ^ c ^ d;
                    k = 32'hca62c1d6;
                end
                t = rot_left(a, 5) + f + e + w[r] + k;
                e = d;
                d = c;
                c = rot_left(b, 30);
                b = a;
                a = t;
            end
            chain[0] = chain[0] + a;
            chain[1] = chain[1] + b;
            chain[2] = chain[2] + c;
            chain[3] = chain[3] + d;
            chain[4] = chain[4] + e;
        endfunction

        // Account for one accepted input word.
        function void note_input(input logic kind, input logic [7:0] data_byte);
            digest_word_t dw;
            if (kind == KIND_ABSORB) begin
                blk[fill] = data_byte;
                fill = fill + 1;
                bit_count = bit_count + 64'd8;
                bytes_absorbed++;
                if (fill == 64) begin
                    compress();
                    fill = 0;
                end
                return;
            end
            // Finish: pad byte, zeros, and an extra block when the length does not fit.
            blk[fill] = 8'h80;
            fill = fill + 1;
            if (fill > 56) begin
                while (fill < 64) begin
                    blk[fill] = 8'h00;
                    fill = fill + 1;
                end
                compress();
                fill = 0;
                extra_blocks++;
            end
            while (fill < 56) begin
                blk[fill] = 8'h00;
                fill = fill + 1;
            end
            for (int i = 0; i < 8; i++)
                blk[56 + i] = bit_count[63 - 8 * i -: 8];
            compress();
            for (int i = 0; i < 5; i++) begin
                dw.word = chain[i];
                dw.idx = 3'(i);
                dw.last = (i == 4);
                digest_q.push_back(dw);
            end
            messages++;
            restart();
        endfunction

        // Compare one accepted output word with the oldest expected digest word.
        function void check_result(input logic [39:0] tdata, input logic tlast);
            digest_word_t dw;
            if (digest_q.size() == 0) begin
                $error("unexpected output word: tdata %h, tlast %b", tdata, tlast);
                errors++;
                return;
            end
            dw = digest_q.pop_front();
            words_checked++;
            if (tdata[31:0] !== dw.word) begin
                $error("digest_word: expected %h, actual %h", dw.word, tdata[31:0]);
                errors++;
            end
            if (tdata[34:32] !== dw.idx) begin
                $error("word_index: expected %0d, actual %0d", dw.idx, tdata[34:32]);
                errors++;
            end
            if (tlast !== dw.last) begin
                $error("last_word: expected %b, actual %b", dw.last, tlast);
                errors++;
            end
            if (tdata[39:35] !== 5'd0) begin
                $error("tdata padding: expected %h, actual %h", 5'd0, tdata[39:35]);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return digest_q.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    sha1_scoreboard sb;

    // Values seen just before the next rising edge.
    logic        in_fire = 1'b0;
    logic        in_kind = 1'b0;
    logic [7:0]  in_byte = 8'h00;
    logic        out_fire = 1'b0;
    logic [39:0] out_tdata = '0;
    logic        out_tlast = 1'b0;

    int unsigned cycles = 0;
    int unsigned burst_left = 0;
    int unsigned items_sent = 0;
    int unsigned msgs_sent = 0;
    logic [7:0]  rx_phase = 8'd0;
    logic [1:0]  rx_mode = 2'd0;

    sha1_byte_stream_hasher uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Sample both channels at the falling edge; they are stable until the next rising edge.
    always @(negedge aclk) begin
        in_fire = (aresetn && s_tvalid && s_tready) === 1'b1;
        in_kind = s_tuser;
        in_byte = s_tdata;
        out_fire = (aresetn && m_tvalid && m_tready) === 1'b1;
        out_tdata = m_tdata;
        out_tlast = m_tlast;
    end

    // Feed accepted words to the scoreboard and watch the cycle budget.
    always @(posedge aclk) begin
        if (in_fire)
            sb.note_input(in_kind, in_byte);
        if (out_fire)
            sb.check_result(out_tdata, out_tlast);
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d digest words outstanding",
                     cycles, sb.pending());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: free flow, random stalls, a fixed pattern, or long stalls, switching to a random mode.
    always @(posedge aclk) begin
        rx_phase <= rx_phase + 8'd1;
        if (rx_phase[5:0] == 6'd0)
            rx_mode <= 2'($urandom_range(0, 3));
        case (rx_mode)
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= ($urandom_range(0, 1) == 1);
            2'd2: m_tready <= (rx_phase % 3 != 0);
            default: m_tready <= (rx_phase[4:0] >= 5'd20);
        endcase
    end

    // Send one input word; bursts of random length are separated by random gaps.
    task automatic send_item(input logic kind, input logic [7:0] data_byte);
        int unsigned gap;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= data_byte;
        do @(posedge aclk); while (!in_fire);
        items_sent++;
    endtask

    // A message of random bytes followed by a finish word with random unused data.
    task automatic send_message(input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            send_item(KIND_ABSORB, 8'($urandom));
        send_item(KIND_FINISH, 8'($urandom));
        msgs_sent++;
    endtask

    initial begin
        int unsigned sel;
        int unsigned msg_len;
        sb = new();
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser <= KIND_ABSORB;
        s_tdata <= 8'h00;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty message with unused data set, then short known messages.
        send_item(KIND_FINISH, 8'ha5);
        send_item(KIND_ABSORB, 8'h61);
        send_item(KIND_ABSORB, 8'h62);
        send_item(KIND_ABSORB, 8'h63);
        send_item(KIND_FINISH, 8'h00);
        send_item(KIND_ABSORB, 8'h00);
        send_item(KIND_ABSORB, 8'hff);
        send_item(KIND_FINISH, 8'hff);
        send_item(KIND_FINISH, 8'h00);
        send_item(KIND_ABSORB, 8'h80);
        send_item(KIND_FINISH, 8'h5a);

        // Random messages: mostly short, many around the length field and block edges.
        while (items_sent < RANDOM_ITEMS || msgs_sent < RANDOM_MESSAGES) begin
            sel = $urandom_range(0, 9);
            if (sel < 6)
                msg_len = $urandom_range(0, 10);
            else if (sel < 9)
                msg_len = $urandom_range(53, 66);
            else
                msg_len = $urandom_range(118, 130);
            // Keep the total close to the item budget.
            if (items_sent + msg_len + 1 > RANDOM_ITEMS)
                msg_len = (items_sent + 1 < RANDOM_ITEMS) ? RANDOM_ITEMS - items_sent - 1 : 0;
            send_message(msg_len);
        end
        s_tvalid <= 1'b0;

        // Drain the remaining digest words, then let the block settle.
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Hashed %0d messages from %0d bytes in %0d input words.",
                 sb.messages, sb.bytes_absorbed, items_sent);
        $display("Checked %0d digest words; %0d messages needed an extra padding block.",
                 sb.words_checked, sb.extra_blocks);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

>>> sha1_byte_stream_hasher.f
+incdir+rtl
rtl/sha1bs_pkg.sv
rtl/sha1bs_datapath.sv
rtl/sha1bs_ctrl.sv
rtl/sha1_byte_stream_hasher.sv
test/tb_top.sv
